### design/ttm_pkg.sv
// Shared definitions for the touch-to-mouse translator: event codes, the
// decoded operation carried from the front end to the back end, and helpers.
// No dependencies.
package ttm_pkg;

    localparam logic [2:0] CMD_MOUSE_DOWN  = 3'd0;
    localparam logic [2:0] CMD_MOUSE_UP    = 3'd1;
    localparam logic [2:0] CMD_MOUSE_MOVE  = 3'd2;
    localparam logic [2:0] CMD_WHEEL       = 3'd3;
    localparam logic [2:0] CMD_TOUCH_START = 3'd4;
    localparam logic [2:0] CMD_TOUCH_MOVE  = 3'd5;
    localparam logic [2:0] CMD_TOUCH_END   = 3'd6;
    localparam logic [2:0] CMD_POLL        = 3'd7;

    localparam logic [15:0] TAP_SLOP_RESET = 16'd25;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0]         cmd;
        logic               skip;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [7:0]         btn_mask;
        logic [9:0]         finger_id;
        logic signed [16:0] pos_sum;
    } t_ttm_op;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] res;
        if (v > 18'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

### design/ttm_front.sv
// Front end: takes event beats, picks the delta operand, builds the button
// mask and the touch coordinate sum, and marks unchanged touches as no-ops.
// Depends on ttm_pkg.
module ttm_front (
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_cmd,
    input  logic signed [15:0]   i_pos_x,
    input  logic signed [15:0]   i_pos_y,
    input  logic signed [15:0]   i_move_x,
    input  logic signed [15:0]   i_move_y,
    input  logic [2:0]           i_button,
    input  logic signed [15:0]   i_wheel_x,
    input  logic signed [15:0]   i_wheel_y,
    input  logic [9:0]           i_finger_id,
    input  logic                 i_finger_changed,
    output logic                 o_push,
    output ttm_pkg::t_ttm_op     o_op,
    input  logic                 i_q_full
);
    import ttm_pkg::*;

    logic is_touch;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign is_touch   = (i_cmd == CMD_TOUCH_START) || (i_cmd == CMD_TOUCH_MOVE) ||
                        (i_cmd == CMD_TOUCH_END);

    always_comb begin
        o_op.cmd       = i_cmd;
        o_op.skip      = is_touch && !i_finger_changed;
        o_op.pos_x     = i_pos_x;
        o_op.pos_y     = i_pos_y;
        o_op.delta_x   = (i_cmd == CMD_WHEEL) ? i_wheel_x : i_move_x;
        o_op.delta_y   = (i_cmd == CMD_WHEEL) ? i_wheel_y : i_move_y;
        o_op.btn_mask  = 8'b1 << i_button;
        o_op.finger_id = i_finger_id;
        o_op.pos_sum   = {i_pos_x[15], i_pos_x} + {i_pos_y[15], i_pos_y};
    end

endmodule

### design/ttm_queue.sv
// Short queue between the front end and the back end.
// Depends on ttm_pkg.
module ttm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ttm_pkg::t_ttm_op i_op,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output ttm_pkg::t_ttm_op o_op
);
    import ttm_pkg::*;

    t_ttm_op             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/ttm_back.sv
// Back end: executes one queued operation per beat against the pointer,
// button, motion, scroll and tap-tracking state, and presents the snapshot.
// Depends on ttm_pkg.
module ttm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_q_valid,
    input  ttm_pkg::t_ttm_op   i_op,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_cursor_x,
    output logic signed [15:0] o_cursor_y,
    output logic [7:0]         o_button_mask,
    output logic signed [15:0] o_frame_dx,
    output logic signed [15:0] o_frame_dy,
    output logic signed [15:0] o_frame_scroll_x,
    output logic signed [15:0] o_frame_scroll_y
);
    import ttm_pkg::*;

    logic [15:0]        r_tap_slop;
    logic               r_out_valid;
    logic signed [15:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [7:0]         r_buttons, n_buttons;
    logic signed [15:0] r_pend_dx, r_pend_dy, n_pend_dx, n_pend_dy;
    logic signed [15:0] r_lat_dx, r_lat_dy, n_lat_dx, n_lat_dy;
    logic signed [15:0] r_pend_sx, r_pend_sy, n_pend_sx, n_pend_sy;
    logic signed [15:0] r_lat_sx, r_lat_sy, n_lat_sx, n_lat_sy;
    logic               r_finger_down, n_finger_down;
    logic [9:0]         r_tracked, n_tracked;
    logic signed [15:0] r_prev_x, r_prev_y, n_prev_x, n_prev_y;
    logic               r_tap_none, n_tap_none;
    logic [9:0]         r_tap_id, n_tap_id;
    logic signed [16:0] r_tap_origin, n_tap_origin;
    logic               r_tap_armed, n_tap_armed;

    logic               tap_hit;
    logic               blocked;
    logic signed [17:0] drift;
    logic [17:0]        drift_abs;
    logic signed [16:0] touch_dx, touch_dy;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_cursor_x       = r_pos_x;
    assign o_cursor_y       = r_pos_y;
    assign o_button_mask    = r_buttons;
    assign o_frame_dx       = r_lat_dx;
    assign o_frame_dy       = r_lat_dy;
    assign o_frame_scroll_x = r_lat_sx;
    assign o_frame_scroll_y = r_lat_sy;

    assign tap_hit   = !r_tap_none && (r_tap_id == i_op.finger_id);
    assign blocked   = r_finger_down && (i_op.finger_id != r_tracked);
    assign drift     = {r_tap_origin[16], r_tap_origin} - {i_op.pos_sum[16], i_op.pos_sum};
    assign drift_abs = drift[17] ? 18'(-drift) : 18'(drift);
    assign touch_dx  = {i_op.pos_x[15], i_op.pos_x} - {r_prev_x[15], r_prev_x};
    assign touch_dy  = {i_op.pos_y[15], i_op.pos_y} - {r_prev_y[15], r_prev_y};

    always_comb begin
        n_pos_x = r_pos_x;       n_pos_y = r_pos_y;
        n_buttons = r_buttons;
        n_pend_dx = r_pend_dx;   n_pend_dy = r_pend_dy;
        n_lat_dx = r_lat_dx;     n_lat_dy = r_lat_dy;
        n_pend_sx = r_pend_sx;   n_pend_sy = r_pend_sy;
        n_lat_sx = r_lat_sx;     n_lat_sy = r_lat_sy;
        n_finger_down = r_finger_down;
        n_tracked = r_tracked;
        n_prev_x = r_prev_x;     n_prev_y = r_prev_y;
        n_tap_none = r_tap_none;
        n_tap_id = r_tap_id;
        n_tap_origin = r_tap_origin;
        n_tap_armed = r_tap_armed;
        if (!i_op.skip) begin
            unique case (i_op.cmd)
                CMD_MOUSE_DOWN, CMD_MOUSE_UP, CMD_MOUSE_MOVE: begin
                    n_pos_x   = i_op.pos_x;
                    n_pos_y   = i_op.pos_y;
                    n_pend_dx = sat16(18'(r_pend_dx) + 18'(i_op.delta_x));
                    n_pend_dy = sat16(18'(r_pend_dy) + 18'(i_op.delta_y));
                    if (i_op.cmd == CMD_MOUSE_DOWN) begin
                        n_buttons = r_buttons | i_op.btn_mask;
                    end else if (i_op.cmd == CMD_MOUSE_UP) begin
                        n_buttons = r_buttons & ~i_op.btn_mask;
                    end
                end
                CMD_WHEEL: begin
                    n_pend_sx = sat16(18'(r_pend_sx) + 18'(i_op.delta_x));
                    n_pend_sy = sat16(18'(r_pend_sy) + 18'(i_op.delta_y));
                end
                CMD_TOUCH_START: begin
                    if (!tap_hit) begin
                        n_tap_armed  = 1'b0;
                        n_tap_none   = 1'b0;
                        n_tap_id     = i_op.finger_id;
                        n_tap_origin = i_op.pos_sum;
                    end
                    if (n_tap_armed) begin
                        n_buttons[0] = 1'b1;
                    end
                    if (!blocked) begin
                        n_finger_down = 1'b1;
                        n_tracked     = i_op.finger_id;
                        n_prev_x      = i_op.pos_x;
                        n_prev_y      = i_op.pos_y;
                    end
                end
                CMD_TOUCH_MOVE: begin
                    if (tap_hit && (drift_abs > {2'b00, r_tap_slop})) begin
                        n_tap_none = 1'b1;
                    end
                    if (!blocked) begin
                        n_prev_x  = i_op.pos_x;
                        n_prev_y  = i_op.pos_y;
                        n_pos_x   = i_op.pos_x;
                        n_pos_y   = i_op.pos_y;
                        n_pend_dx = sat16(18'(r_pend_dx) + 18'(touch_dx));
                        n_pend_dy = sat16(18'(r_pend_dy) + 18'(touch_dy));
                    end
                end
                CMD_TOUCH_END: begin
                    if (i_op.finger_id == r_tracked) begin
                        n_finger_down = 1'b0;
                    end
                    if (tap_hit && !r_tap_armed) begin
                        n_tap_armed = 1'b1;
                    end else if (r_tap_armed) begin
                        n_buttons[0] = 1'b0;
                        n_tap_armed  = 1'b0;
                        n_tap_none   = 1'b1;
                    end
                end
                CMD_POLL: begin
                    n_lat_dx  = r_pend_dx;
                    n_lat_dy  = r_pend_dy;
                    n_lat_sx  = r_pend_sx;
                    n_lat_sy  = r_pend_sy;
                    n_pend_dx = '0;
                    n_pend_dy = '0;
                    n_pend_sx = '0;
                    n_pend_sy = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_slop    <= TAP_SLOP_RESET;
            r_out_valid   <= 1'b0;
            r_pos_x       <= '0;
            r_pos_y       <= '0;
            r_buttons     <= '0;
            r_pend_dx     <= '0;
            r_pend_dy     <= '0;
            r_lat_dx      <= '0;
            r_lat_dy      <= '0;
            r_pend_sx     <= '0;
            r_pend_sy     <= '0;
            r_lat_sx      <= '0;
            r_lat_sy      <= '0;
            r_finger_down <= 1'b0;
            r_tracked     <= '0;
            r_prev_x      <= '0;
            r_prev_y      <= '0;
            r_tap_none    <= 1'b0;
            r_tap_id      <= '0;
            r_tap_origin  <= '0;
            r_tap_armed   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tap_slop <= i_cfg_data;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_pos_x       <= n_pos_x;
                r_pos_y       <= n_pos_y;
                r_buttons     <= n_buttons;
                r_pend_dx     <= n_pend_dx;
                r_pend_dy     <= n_pend_dy;
                r_lat_dx      <= n_lat_dx;
                r_lat_dy      <= n_lat_dy;
                r_pend_sx     <= n_pend_sx;
                r_pend_sy     <= n_pend_sy;
                r_lat_sx      <= n_lat_sx;
                r_lat_sy      <= n_lat_sy;
                r_finger_down <= n_finger_down;
                r_tracked     <= n_tracked;
                r_prev_x      <= n_prev_x;
                r_prev_y      <= n_prev_y;
                r_tap_none    <= n_tap_none;
                r_tap_id      <= n_tap_id;
                r_tap_origin  <= n_tap_origin;
                r_tap_armed   <= n_tap_armed;
            end
        end
    end

endmodule

### design/touch_to_mouse_translator.sv
// Touch-to-mouse translator: one event beat in and one snapshot beat out per
// event, one beat per cycle sustained while the output is not stalled; an event
// lands in the two-entry queue when it is taken, and the state/result register
// of the back end then loads from the queue head once the output can accept it.
// The input stalls only when the queue is full behind a stalled output. The tap
// slop register is always ready.
module touch_to_mouse_translator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_cmd,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_move_x,
    input  logic signed [15:0] i_move_y,
    input  logic [2:0]         i_button,
    input  logic signed [15:0] i_wheel_x,
    input  logic signed [15:0] i_wheel_y,
    input  logic [9:0]         i_finger_id,
    input  logic               i_finger_changed,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_cursor_x,
    output logic signed [15:0] o_cursor_y,
    output logic [7:0]         o_button_mask,
    output logic signed [15:0] o_frame_dx,
    output logic signed [15:0] o_frame_dy,
    output logic signed [15:0] o_frame_scroll_x,
    output logic signed [15:0] o_frame_scroll_y
);
    import ttm_pkg::*;

    logic    push, pop, q_full, q_valid;
    t_ttm_op push_op, head_op;

    assign o_cfg_ready = 1'b1;

    ttm_front u_front (
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_move_x         (i_move_x),
        .i_move_y         (i_move_y),
        .i_button         (i_button),
        .i_wheel_x        (i_wheel_x),
        .i_wheel_y        (i_wheel_y),
        .i_finger_id      (i_finger_id),
        .i_finger_changed (i_finger_changed),
        .o_push           (push),
        .o_op             (push_op),
        .i_q_full         (q_full)
    );

    ttm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    ttm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_q_valid        (q_valid),
        .i_op             (head_op),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cursor_x       (o_cursor_x),
        .o_cursor_y       (o_cursor_y),
        .o_button_mask    (o_button_mask),
        .o_frame_dx       (o_frame_dx),
        .o_frame_dy       (o_frame_dy),
        .o_frame_scroll_x (o_frame_scroll_x),
        .o_frame_scroll_y (o_frame_scroll_y)
    );

endmodule

### design/ttm_checker.sv
// Port-level checks for touch_to_mouse_translator, attached by bind.
// Depends on the top level's port list only.
module ttm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_cursor_x,
    input logic [7:0]         o_button_mask
);
    logic [2:0] r_inflight;
    logic       in_beat, out_beat;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_beat = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(in_beat) - 3'(out_beat);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_cursor_x) && $stable(o_button_mask))
        else $error("result changed while stalled");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_inflight != 3'd0)
        else $error("result without a pending event");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == 3'd3 |-> !o_in_ready)
        else $error("event taken with queue and result register full");

endmodule

bind touch_to_mouse_translator ttm_checker u_ttm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_cursor_x    (o_cursor_x),
    .o_button_mask (o_button_mask)
);

### tb/testbench.sv
// Self-checking bench for touch_to_mouse_translator: a directed event table, then random
// gestures under several tap-slop settings; snapshots checked against fixed rows or a model.
// Depends on ttm_pkg for the event codes and the tap-slop reset value.
module testbench;
    import ttm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_EVENTS  = 290;
    localparam int PHASES        = 6;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic [2:0]         button;
        logic signed [15:0] wheel_x;
        logic signed [15:0] wheel_y;
        logic [9:0]         finger_id;
        logic               finger_changed;
    } t_touch_evt;

    typedef struct packed {
        logic signed [15:0] cursor_x;
        logic signed [15:0] cursor_y;
        logic [7:0]         buttons;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] scr_x;
        logic signed [15:0] scr_y;
    } t_snapshot;

    typedef struct {
        t_touch_evt ev;
        bit         fixed;
        t_snapshot  want;
    } t_table_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_cmd = '0;
    logic signed [15:0] i_pos_x = '0;
    logic signed [15:0] i_pos_y = '0;
    logic signed [15:0] i_move_x = '0;
    logic signed [15:0] i_move_y = '0;
    logic [2:0]         i_button = '0;
    logic signed [15:0] i_wheel_x = '0;
    logic signed [15:0] i_wheel_y = '0;
    logic [9:0]         i_finger_id = '0;
    logic               i_finger_changed = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    logic signed [15:0] o_cursor_x;
    logic signed [15:0] o_cursor_y;
    logic [7:0]         o_button_mask;
    logic signed [15:0] o_frame_dx;
    logic signed [15:0] o_frame_dy;
    logic signed [15:0] o_frame_scroll_x;
    logic signed [15:0] o_frame_scroll_y;

    touch_to_mouse_translator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_move_x         (i_move_x),
        .i_move_y         (i_move_y),
        .i_button         (i_button),
        .i_wheel_x        (i_wheel_x),
        .i_wheel_y        (i_wheel_y),
        .i_finger_id      (i_finger_id),
        .i_finger_changed (i_finger_changed),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cursor_x       (o_cursor_x),
        .o_cursor_y       (o_cursor_y),
        .o_button_mask    (o_button_mask),
        .o_frame_dx       (o_frame_dx),
        .o_frame_dy       (o_frame_dy),
        .o_frame_scroll_x (o_frame_scroll_x),
        .o_frame_scroll_y (o_frame_scroll_y)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [15:0]        slop_cfg;
    logic signed [15:0] cur_x, cur_y;
    logic [7:0]         held_btns;
    logic signed [15:0] acc_dx, acc_dy, acc_sx, acc_sy;
    logic signed [15:0] lat_dx, lat_dy, lat_sx, lat_sy;
    logic               touching;
    int                 drag_finger;
    logic signed [15:0] last_tx, last_ty;
    int                 tap_id;
    int                 tap_sum;
    logic               tap_ready;

    t_snapshot   pending_snaps[$];
    t_touch_evt  plan_q[$];
    t_table_row  dir_rows[$];
    int unsigned err_count;
    int unsigned events_sent;
    int unsigned snaps_checked;
    int unsigned cycle_cnt;
    bit          tx_idle_en;
    bit          rx_idle_en;
    bit          hold_req;

    task automatic clear_model();
        slop_cfg    = TAP_SLOP_RESET;
        cur_x       = '0;
        cur_y       = '0;
        held_btns   = '0;
        acc_dx      = '0;
        acc_dy      = '0;
        acc_sx      = '0;
        acc_sy      = '0;
        lat_dx      = '0;
        lat_dy      = '0;
        lat_sx      = '0;
        lat_sy      = '0;
        touching    = 1'b0;
        drag_finger = 0;
        last_tx     = '0;
        last_ty     = '0;
        tap_id      = 0;
        tap_sum     = 0;
        tap_ready   = 1'b0;
    endtask

    function automatic logic signed [15:0] clamp_add(logic signed [15:0] a, int b);
        int s;
        s = int'(a) + b;
        if (s > 32767) begin
            s = 32767;
        end else if (s < -32768) begin
            s = -32768;
        end
        return s[15:0];
    endfunction

    function automatic t_snapshot predict_snapshot(t_touch_evt ev);
        int fid;
        int tsum;
        int drift;
        fid  = int'(ev.finger_id);
        tsum = int'(ev.pos_x) + int'(ev.pos_y);
        case (ev.cmd)
            CMD_MOUSE_DOWN, CMD_MOUSE_UP, CMD_MOUSE_MOVE: begin
                cur_x  = ev.pos_x;
                cur_y  = ev.pos_y;
                acc_dx = clamp_add(acc_dx, int'(ev.move_x));
                acc_dy = clamp_add(acc_dy, int'(ev.move_y));
                if (ev.cmd == CMD_MOUSE_DOWN) begin
                    held_btns[ev.button] = 1'b1;
                end else if (ev.cmd == CMD_MOUSE_UP) begin
                    held_btns[ev.button] = 1'b0;
                end
            end
            CMD_WHEEL: begin
                acc_sx = clamp_add(acc_sx, int'(ev.wheel_x));
                acc_sy = clamp_add(acc_sy, int'(ev.wheel_y));
            end
            CMD_POLL: begin
                lat_dx = acc_dx;
                lat_dy = acc_dy;
                lat_sx = acc_sx;
                lat_sy = acc_sy;
                acc_dx = '0;
                acc_dy = '0;
                acc_sx = '0;
                acc_sy = '0;
            end
            default: begin
                if (ev.finger_changed) begin
                    if (ev.cmd == CMD_TOUCH_START && tap_id != fid) begin
                        tap_ready = 1'b0;
                        tap_id    = fid;
                        tap_sum   = tsum;
                    end
                    if (ev.cmd == CMD_TOUCH_START && tap_ready) begin
                        held_btns[0] = 1'b1;
                    end
                    if (ev.cmd == CMD_TOUCH_MOVE && tap_id == fid) begin
                        drift = tap_sum - tsum;
                        if (drift < 0) begin
                            drift = -drift;
                        end
                        if (drift > int'(slop_cfg)) begin
                            tap_id = -1;
                        end
                    end
                    if (ev.cmd == CMD_TOUCH_END) begin
                        if (fid == drag_finger) begin
                            touching = 1'b0;
                        end
                        if (tap_id == fid && !tap_ready) begin
                            tap_ready = 1'b1;
                        end else if (tap_ready) begin
                            held_btns[0] = 1'b0;
                            tap_ready    = 1'b0;
                            tap_id       = -1;
                        end
                    end else if (!(touching && fid != drag_finger)) begin
                        if (ev.cmd == CMD_TOUCH_START) begin
                            touching    = 1'b1;
                            drag_finger = fid;
                        end else begin
                            acc_dx = clamp_add(acc_dx, int'(ev.pos_x) - int'(last_tx));
                            acc_dy = clamp_add(acc_dy, int'(ev.pos_y) - int'(last_ty));
                            cur_x  = ev.pos_x;
                            cur_y  = ev.pos_y;
                        end
                        last_tx = ev.pos_x;
                        last_ty = ev.pos_y;
                    end
                end
            end
        endcase
        return {cur_x, cur_y, held_btns, lat_dx, lat_dy, lat_sx, lat_sy};
    endfunction

    function automatic t_touch_evt rnd_event();
        bit [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(t_touch_evt)-1:0];
    endfunction

    function automatic t_touch_evt touch_ev(logic [2:0] cmd, int fid, int x, int y);
        t_touch_evt e;
        e                = rnd_event();
        e.cmd            = cmd;
        e.finger_id      = fid[9:0];
        e.pos_x          = x[15:0];
        e.pos_y          = y[15:0];
        e.finger_changed = 1'b1;
        return e;
    endfunction

    function automatic t_touch_evt mk_ev(logic [2:0] cmd, int px, int py, int mx, int my,
                                         int btn, int wx, int wy, int fid, int chg);
        t_touch_evt e;
        e.cmd            = cmd;
        e.pos_x          = px[15:0];
        e.pos_y          = py[15:0];
        e.move_x         = mx[15:0];
        e.move_y         = my[15:0];
        e.button         = btn[2:0];
        e.wheel_x        = wx[15:0];
        e.wheel_y        = wy[15:0];
        e.finger_id      = fid[9:0];
        e.finger_changed = chg[0];
        return e;
    endfunction

    function automatic t_snapshot mk_snap(int cx, int cy, logic [7:0] b,
                                          int dx, int dy, int sx, int sy);
        return {cx[15:0], cy[15:0], b, dx[15:0], dy[15:0], sx[15:0], sy[15:0]};
    endfunction

    function automatic int rnd_span(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic add_row(t_touch_evt ev, bit fixed, t_snapshot want);
        t_table_row r;
        r.ev    = ev;
        r.fixed = fixed;
        r.want  = want;
        dir_rows.push_back(r);
    endtask

    task automatic note_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    task automatic offer_event(t_touch_evt ev, bit use_fixed, t_snapshot fixed_snap);
        t_snapshot want;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_cmd            <= ev.cmd;
        i_pos_x          <= ev.pos_x;
        i_pos_y          <= ev.pos_y;
        i_move_x         <= ev.move_x;
        i_move_y         <= ev.move_y;
        i_button         <= ev.button;
        i_wheel_x        <= ev.wheel_x;
        i_wheel_y        <= ev.wheel_y;
        i_finger_id      <= ev.finger_id;
        i_finger_changed <= ev.finger_changed;
        i_in_valid       <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        want = predict_snapshot(ev);
        if (use_fixed) begin
            want = fixed_snap;
        end
        pending_snaps.push_back(want);
        events_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_snaps.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_slop(logic [15:0] v);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        slop_cfg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic plan_gesture();
        t_touch_evt e;
        int kind, f, g, bx, by, lim;
        kind = $urandom_range(0, 11);
        f    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 3);
        g    = (f + 1 + $urandom_range(0, 2)) % 1024;
        lim  = (slop_cfg > 16'd13000) ? 20000 : int'(slop_cfg) * 3 / 2 + 3;
        bx   = rnd_span(2000);
        by   = rnd_span(2000);
        case (kind)
            0, 1, 2: begin
                plan_q.push_back(touch_ev(CMD_TOUCH_START, f, bx, by));
                repeat ($urandom_range(0, 2)) begin
                    plan_q.push_back(touch_ev(CMD_TOUCH_MOVE, f, bx + rnd_span(lim),
                                              by + rnd_span(lim)));
                end
                plan_q.push_back(touch_ev(CMD_TOUCH_END, f, bx, by));
                if ($urandom_range(0, 2) != 0) begin
                    plan_q.push_back(touch_ev(CMD_TOUCH_START, f, bx + rnd_span(lim),
                                              by + rnd_span(lim)));
                    repeat ($urandom_range(0, 3)) begin
                        bx += rnd_span(3000);
                        by += rnd_span(3000);
                        plan_q.push_back(touch_ev(CMD_TOUCH_MOVE, f, bx, by));
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        plan_q.push_back(touch_ev(CMD_POLL, f, bx, by));
                    end
                    plan_q.push_back(touch_ev(CMD_TOUCH_END, f, bx, by));
                end
            end
            3, 4: begin
                plan_q.push_back(touch_ev(CMD_TOUCH_START, f, bx, by));
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 5) == 0) begin
                        bx = rnd_span(32768);
                        by = rnd_span(32768);
                    end else begin
                        bx += rnd_span(500);
                        by += rnd_span(500);
                    end
                    plan_q.push_back(touch_ev(CMD_TOUCH_MOVE, f, bx, by));
                end
                plan_q.push_back(touch_ev(CMD_TOUCH_END, f, bx, by));
            end
            5: begin
                plan_q.push_back(touch_ev(CMD_TOUCH_START, f, bx, by));
                plan_q.push_back(touch_ev(CMD_TOUCH_START, g, by, bx));
                plan_q.push_back(touch_ev(CMD_TOUCH_MOVE, g, rnd_span(9000), rnd_span(9000)));
                plan_q.push_back(touch_ev(CMD_TOUCH_MOVE, f, bx + rnd_span(lim), by));
                plan_q.push_back(touch_ev(CMD_TOUCH_END, g, bx, by));
                plan_q.push_back(touch_ev(CMD_TOUCH_END, f, bx, by));
            end
            6: begin
                repeat ($urandom_range(1, 4)) begin
                    e     = rnd_event();
                    e.cmd = ($urandom_range(0, 2) == 0) ? CMD_MOUSE_MOVE :
                            ($urandom_range(0, 1) == 0) ? CMD_MOUSE_DOWN : CMD_MOUSE_UP;
                    plan_q.push_back(e);
                end
            end
            7: begin
                repeat ($urandom_range(1, 3)) begin
                    e     = rnd_event();
                    e.cmd = CMD_WHEEL;
                    plan_q.push_back(e);
                end
            end
            8: begin
                e     = rnd_event();
                e.cmd = CMD_POLL;
                plan_q.push_back(e);
            end
            9, 10: begin
                plan_q.push_back(rnd_event());
            end
            default: begin
                e = touch_ev(CMD_TOUCH_END, f, bx, by);
                if ($urandom_range(0, 1) == 0) begin
                    e.cmd            = ($urandom_range(0, 1) == 0) ? CMD_TOUCH_START
                                                                   : CMD_TOUCH_MOVE;
                    e.finger_changed = 1'b0;
                end
                plan_q.push_back(e);
            end
        endcase
    endtask

    initial begin
        int hold_cycles;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < 80) begin
                    @(negedge i_clk);
                    hold_cycles++;
                end
                i_out_ready <= 1'b1;
                hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_snapshot got;
        t_snapshot want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_cursor_x, o_cursor_y, o_button_mask, o_frame_dx, o_frame_dy,
                   o_frame_scroll_x, o_frame_scroll_y};
            if (pending_snaps.size() == 0) begin
                note_error("snapshot beat with no event outstanding");
            end else begin
                want = pending_snaps.pop_front();
                snaps_checked++;
                if (got !== want) begin
                    note_error($sformatf({"snapshot %0d mismatch: want cur=(%0d,%0d) btn=%h ",
                        "d=(%0d,%0d) s=(%0d,%0d) got cur=(%0d,%0d) btn=%h d=(%0d,%0d) ",
                        "s=(%0d,%0d)"}, snaps_checked,
                        want.cursor_x, want.cursor_y, want.buttons, want.dx, want.dy,
                        want.scr_x, want.scr_y, got.cursor_x, got.cursor_y,
                        got.buttons, got.dx, got.dy, got.scr_x, got.scr_y));
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d snapshots outstanding",
                 cycle_cnt, pending_snaps.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int ph;
        int k;
        int slop_plan[PHASES];
        clear_model();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        slop_plan  = '{0, 65535, 1, 0, 25, 0};
        slop_plan[3] = $urandom_range(0, 65535);
        slop_plan[5] = $urandom_range(2, 400);

        add_row(mk_ev(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_snap(0, 0, 8'h00, 0, 0, 0, 0));
        add_row(mk_ev(CMD_MOUSE_DOWN, 32767, -32768, 32767, -32768, 7, 0, 0, 0, 0), 1'b1,
                mk_snap(32767, -32768, 8'h80, 0, 0, 0, 0));
        add_row(mk_ev(CMD_MOUSE_MOVE, -32768, 32767, 32767, -32768, 0, 0, 0, 0, 0), 1'b1,
                mk_snap(-32768, 32767, 8'h80, 0, 0, 0, 0));
        add_row(mk_ev(CMD_WHEEL, 0, 0, 0, 0, 0, -32768, 32767, 0, 0), 1'b1,
                mk_snap(-32768, 32767, 8'h80, 0, 0, 0, 0));
        add_row(mk_ev(CMD_WHEEL, 0, 0, 0, 0, 0, -32768, 32767, 0, 0), 1'b1,
                mk_snap(-32768, 32767, 8'h80, 0, 0, 0, 0));
        add_row(mk_ev(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_snap(-32768, 32767, 8'h80, 32767, -32768, -32768, 32767));
        add_row(mk_ev(CMD_MOUSE_UP, 0, 0, 0, 0, 7, 0, 0, 0, 0), 1'b1,
                mk_snap(0, 0, 8'h00, 32767, -32768, -32768, 32767));
        add_row(mk_ev(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_snap(0, 0, 8'h00, 0, 0, 0, 0));
        add_row(mk_ev(CMD_MOUSE_DOWN, 5, -5, -1, 1, 1, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_START, 100, 200, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_START, 100, 200, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_MOVE, 110, 205, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_MOVE, 0, 0, 0, 0, 0, 0, 0, 5, 1), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_END, 110, 205, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_START, 110, 205, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_MOVE, 120, 215, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_END, 120, 215, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_START, 32767, 32767, 0, 0, 0, 0, 0, 1023, 1), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_MOVE, -32768, -32768, 0, 0, 0, 0, 0, 1023, 1), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_END, -32768, -32768, 0, 0, 0, 0, 0, 1023, 1), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_MOVE, -7, 9, 0, 0, 0, 0, 0, 3, 1), 1'b0, '0);
        add_row(mk_ev(CMD_TOUCH_END, 0, 0, 0, 0, 0, 0, 0, 7, 0), 1'b0, '0);
        add_row(mk_ev(CMD_WHEEL, 0, 0, 0, 0, 0, 1, -1, 0, 0), 1'b0, '0);
        add_row(mk_ev(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_ev(CMD_MOUSE_UP, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1'b0, '0);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            offer_event(dir_rows[i].ev, dir_rows[i].fixed, dir_rows[i].want);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_slop(slop_plan[ph][15:0]);
            tx_idle_en = (ph != PHASES - 1);
            rx_idle_en = (ph != PHASES - 1);
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            for (k = 0; k < PHASE_EVENTS; k++) begin
                if (ph == 3 && k == PHASE_EVENTS / 2) begin
                    wait_drained();
                end
                if (plan_q.size() == 0) begin
                    plan_gesture();
                end
                offer_event(plan_q.pop_front(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("%0d events sent, %0d snapshots checked over %0d tap-slop settings",
                 events_sent, snaps_checked, PHASES + 1);
        $display("%0d mismatches, %0d cycles", err_count, cycle_cnt);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
